>>> rtl/rgba_median_window_filter_top_assert.svh
// assertion macros for the rgba median window filter
// included by the rtl files that check their own logic
`ifndef RGBA_MEDIAN_WINDOW_FILTER_TOP_ASSERT_SVH
`define RGBA_MEDIAN_WINDOW_FILTER_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define RMWF_ASSERT_ALWAYS(label, clk, rstn, cond) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond)) \
        else $error("assertion failed");
`define RMWF_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
`else
`define RMWF_ASSERT_ALWAYS(label, clk, rstn, cond)
`define RMWF_ASSERT_IMPL(label, clk, rstn, ante, cons)
`endif
`endif

>>> rtl/rmwf_pkg.sv
// shared types and constants of the rgba median window filter
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package rmwf_pkg;
    localparam int DEF_MAX_RADIUS = 8;
    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int RAD_W   = 4;
    localparam int WID_W   = 11;
    localparam int HGT_W   = 13;
    localparam int ROW_W   = 12;
    localparam int HEIGHT_LIMIT = 4096;
    localparam int CFG_DATA_W = 13;
    localparam int CFG_IDX_W  = 2;

    typedef logic [3:0][7:0] pix_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RADIUS = 2'd0,
        REG_WIDTH  = 2'd1,
        REG_HEIGHT = 2'd2
    } reg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_GATHER,
        ST_FLUSH,
        ST_RESULT
    } state_t;

    typedef struct packed {
        logic in_ready;
        logic chain_clear;
        logic gather_run;
        logic load_result;
    } ctrl_t;
endpackage
`default_nettype wire

>>> rtl/rmwf_line_store.sv
// line store: one write port, one registered read port
// uses rmwf_pkg for the pixel type
`timescale 1ns / 1ps
`default_nettype none
module rmwf_line_store
    import rmwf_pkg::*;
#(
    parameter int DEPTH = 17424,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              aclk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  pix_t                   wr_data,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output pix_t                   rd_data
);
    pix_t mem [DEPTH];
    pix_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;
endmodule
`default_nettype wire

>>> rtl/rmwf_cell.sv
// one sorting cell: keeps the smaller value per channel, passes the larger on
// uses rmwf_pkg for the pixel type
`timescale 1ns / 1ps
`default_nettype none
module rmwf_cell
    import rmwf_pkg::*;
(
    input  wire logic aclk,
    input  wire logic clear,
    input  wire logic entry,
    input  pix_t      bus_in,
    input  pix_t      prev_in,
    output pix_t      keep_out,
    output pix_t      pass_out
);
    pix_t keep_reg, keep_next;
    pix_t pass_reg, pass_next;
    pix_t incoming;

    always_comb begin
        incoming = entry ? bus_in : prev_in;
        for (int c = 0; c < 4; c++) begin
            if (incoming[c] < keep_reg[c]) begin
                keep_next[c] = incoming[c];
                pass_next[c] = keep_reg[c];
            end else begin
                keep_next[c] = keep_reg[c];
                pass_next[c] = incoming[c];
            end
        end
    end

    // all ones acts as an empty slot: it never displaces a held value
    always_ff @(posedge aclk) begin
        if (clear) begin
            keep_reg <= '1;
            pass_reg <= '1;
        end else begin
            keep_reg <= keep_next;
            pass_reg <= pass_next;
        end
    end

    assign keep_out = keep_reg;
    assign pass_out = pass_reg;
endmodule
`default_nettype wire

>>> rtl/rmwf_sort_chain.sv
// chain of sorting cells selecting the median per channel
// uses rmwf_pkg and rmwf_cell
`timescale 1ns / 1ps
`default_nettype none
module rmwf_sort_chain
    import rmwf_pkg::*;
#(
    parameter int NCELL = 145,
    localparam int IDX_W = $clog2(NCELL)
) (
    input  wire logic             aclk,
    input  wire logic             clear,
    input  wire logic [IDX_W-1:0] start_idx,
    input  pix_t                  bus_in,
    output pix_t                  median_out
);
    pix_t pass_w [NCELL];
    pix_t keep_w [NCELL];

    // values enter at start_idx; the last cell ends up with the rank-th smallest
    for (genvar i = 0; i < NCELL; i++) begin : g_cell
        pix_t prev;
        if (i == 0) begin : g_first
            assign prev = '1;
        end else begin : g_rest
            assign prev = pass_w[i-1];
        end
        rmwf_cell u_cell (
            .aclk     (aclk),
            .clear    (clear),
            .entry    (start_idx == IDX_W'(i)),
            .bus_in   (bus_in),
            .prev_in  (prev),
            .keep_out (keep_w[i]),
            .pass_out (pass_w[i])
        );
    end

    assign median_out = keep_w[NCELL-1];
endmodule
`default_nettype wire

>>> rtl/rgba_median_window_filter_top.sv
// rgba median window filter, top level: config, counters, window fetch, sequencer
// uses rmwf_pkg, rmwf_line_store, rmwf_sort_chain and the assertion header
//
// channels: s_ carries one request per item, s_tuser = kind (0 pixel, 1 drain),
// s_tdata = red, green, blue, alpha. m_ carries results, m_tdata the four
// channel medians, m_tlast marks the result of the last pixel of the frame.
// cfg_ writes radius (0), frame width (1), frame height (2); a write restarts
// the frame counters, writes beyond the list are ignored.
// a result for raster position q is produced by the pixel at q + r*w + r, or by
// drain requests once the whole frame is in.
// a result is built in steps: the window is read, one pixel per cycle from the
// single line store read port, passed through the fetch pipe and the sorting
// chain, and loaded into the output register; NCELL = (2R+1)^2/2 + 1 for the
// maximum radius R. the next request is taken in the cycle after the result is
// loaded. requests that give no result leave the sequencer idle.
// one request is worked on at a time; s_tready is low while a result is built.
// reset clears counters and sets radius 1, width 1024, height 1; the line
// store needs no clearing since every read hits a pixel of the current frame.
// when the receiver stalls the finished result waits in the output register
// and the next result waits until that one is taken.
`timescale 1ns / 1ps
`default_nettype none
`include "rgba_median_window_filter_top_assert.svh"
module rgba_median_window_filter_top
    import rmwf_pkg::*;
#(
    parameter int MAX_RADIUS = DEF_MAX_RADIUS,
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [31:0]           s_tdata,  // in_red, in_green, in_blue, in_alpha
    input  wire logic                  s_tuser,  // kind
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [31:0]                m_tdata,  // out_red, out_green, out_blue, out_alpha
    output logic                       m_tlast,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);
    localparam int DEPTH  = (2 * MAX_RADIUS + 1) * MAX_WIDTH + 2 * MAX_RADIUS;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int POS_W  = ROW_W + COL_W;
    localparam int XS_W   = (COL_W > WID_W ? COL_W : WID_W) + 2;
    localparam int YS_W   = HGT_W + 2;
    localparam int OFF_W  = $clog2(2 * MAX_RADIUS + 1);
    localparam int NCELL  = ((2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1)) / 2 + 1;
    localparam int IDX_W  = $clog2(NCELL);
    localparam int FLUSH_LEN = NCELL + 5;
    localparam int FL_W   = $clog2(FLUSH_LEN);

    state_t state_reg, state_next;
    ctrl_t  ctrl;

    logic [RAD_W-1:0] radius_reg;
    logic [WID_W-1:0] width_reg;
    logic [HGT_W-1:0] height_reg;
    logic [COL_W-1:0] in_col_reg, out_col_reg;
    logic [ROW_W-1:0] in_row_reg, out_row_reg;
    logic             complete_reg;
    logic [POS_W-1:0]  in_pos_reg;
    logic [ADDR_W-1:0] in_addr_reg;

    logic [OFF_W-1:0] dx_reg, dy_reg;
    logic [FL_W-1:0]  flush_cnt_reg;
    logic [IDX_W-1:0] start_reg;

    logic s_fire, cfg_fire, restart, pix_take, want_result;
    logic in_col_last, in_row_last, out_col_last, out_row_last, gather_last;
    logic [14:0] latency;
    logic [OFF_W-1:0] side_m1;

    always_comb begin
        s_fire   = s_tvalid && s_tready;
        cfg_fire = cfg_valid && cfg_ready;
        pix_take = s_fire && !s_tuser && !complete_reg;
        latency  = 15'(radius_reg * width_reg) + 15'(radius_reg);
        want_result = s_fire && (s_tuser ? complete_reg
                                         : (!complete_reg && in_pos_reg >= POS_W'(latency)));
        in_col_last  = (XS_W'(in_col_reg) + XS_W'(1)) == XS_W'(width_reg);
        in_row_last  = (YS_W'(in_row_reg) + YS_W'(1)) == YS_W'(height_reg);
        out_col_last = (XS_W'(out_col_reg) + XS_W'(1)) == XS_W'(width_reg);
        out_row_last = (YS_W'(out_row_reg) + YS_W'(1)) == YS_W'(height_reg);
        side_m1      = OFF_W'({radius_reg, 1'b0});
        gather_last  = (dx_reg == side_m1) && (dy_reg == side_m1);
        restart      = (cfg_fire && cfg_index <= REG_HEIGHT)
                    || (ctrl.load_result && out_col_last && out_row_last);
    end

    assign cfg_ready = 1'b1;

    // configuration registers, saturated on write
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radius_reg <= RAD_W'(1);
            width_reg  <= WID_W'(MAX_WIDTH < 1024 ? MAX_WIDTH : 1024);
            height_reg <= HGT_W'(1);
        end else if (cfg_fire) begin
            case (cfg_index)
                REG_RADIUS: begin
                    if (cfg_data[RAD_W-1:0] == '0) radius_reg <= RAD_W'(1);
                    else if (int'(cfg_data[RAD_W-1:0]) > MAX_RADIUS)
                        radius_reg <= RAD_W'(MAX_RADIUS);
                    else radius_reg <= cfg_data[RAD_W-1:0];
                end
                REG_WIDTH: begin
                    if (cfg_data[WID_W-1:0] == '0) width_reg <= WID_W'(1);
                    else if (int'(cfg_data[WID_W-1:0]) > MAX_WIDTH)
                        width_reg <= WID_W'(MAX_WIDTH);
                    else width_reg <= cfg_data[WID_W-1:0];
                end
                REG_HEIGHT: begin
                    if (cfg_data == '0) height_reg <= HGT_W'(1);
                    else if (int'(cfg_data) > HEIGHT_LIMIT)
                        height_reg <= HGT_W'(HEIGHT_LIMIT);
                    else height_reg <= cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    // input side counters
    always_ff @(posedge aclk) begin
        if (!aresetn || restart) begin
            in_col_reg   <= '0;
            in_row_reg   <= '0;
            complete_reg <= 1'b0;
            in_pos_reg   <= '0;
            in_addr_reg  <= '0;
        end else if (pix_take) begin
            in_pos_reg  <= in_pos_reg + POS_W'(1);
            in_addr_reg <= (in_addr_reg == ADDR_W'(DEPTH - 1)) ? '0
                                                                : in_addr_reg + ADDR_W'(1);
            if (in_col_last) begin
                in_col_reg <= '0;
                if (in_row_last) complete_reg <= 1'b1;
                else in_row_reg <= in_row_reg + ROW_W'(1);
            end else begin
                in_col_reg <= in_col_reg + COL_W'(1);
            end
        end
    end

    // output side counters
    always_ff @(posedge aclk) begin
        if (!aresetn || restart) begin
            out_col_reg <= '0;
            out_row_reg <= '0;
        end else if (ctrl.load_result) begin
            if (out_col_last) begin
                out_col_reg <= '0;
                out_row_reg <= out_row_reg + ROW_W'(1);
            end else begin
                out_col_reg <= out_col_reg + COL_W'(1);
            end
        end
    end

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= ST_IDLE;
        else state_reg <= state_next;
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (want_result) state_next = ST_GATHER;
            ST_GATHER: if (gather_last) state_next = ST_FLUSH;
            ST_FLUSH:  if (flush_cnt_reg == FL_W'(FLUSH_LEN - 1)) state_next = ST_RESULT;
            ST_RESULT: if (!m_tvalid || m_tready) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        ctrl = '0;
        case (state_reg)
            ST_IDLE: begin
                ctrl.in_ready    = 1'b1;
                ctrl.chain_clear = 1'b1;
            end
            ST_GATHER: ctrl.gather_run = 1'b1;
            ST_FLUSH: begin
            end
            ST_RESULT: ctrl.load_result = !m_tvalid || m_tready;
            default: begin
            end
        endcase
    end

    assign s_tready = ctrl.in_ready;

    // window walk and rank of the median cell
    always_ff @(posedge aclk) begin
        if (!aresetn || !ctrl.gather_run) begin
            dx_reg <= '0;
            dy_reg <= '0;
        end else if (dx_reg == side_m1) begin
            dx_reg <= '0;
            dy_reg <= dy_reg + OFF_W'(1);
        end else begin
            dx_reg <= dx_reg + OFF_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || state_reg != ST_FLUSH) flush_cnt_reg <= '0;
        else flush_cnt_reg <= flush_cnt_reg + FL_W'(1);
    end

    logic [5:0]  side_w;
    logic [11:0] side_sq;
    always_comb begin
        side_w  = {1'b0, radius_reg, 1'b1};
        side_sq = 12'(side_w * side_w);
    end

    always_ff @(posedge aclk) begin
        if (ctrl.chain_clear) start_reg <= IDX_W'(NCELL - 1) - IDX_W'(side_sq >> 1);
    end

    // fetch pipe: clamp, multiply, wrap address, read
    logic signed [XS_W-1:0] x_raw;
    logic signed [YS_W-1:0] y_raw;
    logic [COL_W-1:0] xs_next, xs_reg;
    logic [ROW_W-1:0] ys_next, ys_reg;
    logic [POS_W-1:0] rdpos_reg, diff;
    logic [ADDR_W:0]  addr_sub, addr_fix;
    logic [ADDR_W-1:0] rd_addr_reg;
    logic va_reg, vb_reg, vc_reg, vd_reg;
    pix_t rd_data, bus, median;

    always_comb begin
        x_raw = $signed(XS_W'(out_col_reg)) + $signed(XS_W'(dx_reg))
              - $signed(XS_W'(radius_reg));
        y_raw = $signed(YS_W'(out_row_reg)) + $signed(YS_W'(dy_reg))
              - $signed(YS_W'(radius_reg));
        if (x_raw < 0) xs_next = '0;
        else if (x_raw >= $signed(XS_W'(width_reg))) xs_next = COL_W'(width_reg - WID_W'(1));
        else xs_next = COL_W'(x_raw);
        if (y_raw < 0) ys_next = '0;
        else if (y_raw >= $signed(YS_W'(height_reg)))
            ys_next = ROW_W'(height_reg - HGT_W'(1));
        else ys_next = ROW_W'(y_raw);
        // distance back from the next write position is below the store depth
        diff     = in_pos_reg - rdpos_reg;
        addr_sub = {1'b0, in_addr_reg} - (ADDR_W + 1)'(diff);
        addr_fix = addr_sub[ADDR_W] ? addr_sub + (ADDR_W + 1)'(DEPTH) : addr_sub;
    end

    always_ff @(posedge aclk) begin
        xs_reg      <= xs_next;
        ys_reg      <= ys_next;
        rdpos_reg   <= POS_W'(ys_reg * width_reg) + POS_W'(xs_reg);
        rd_addr_reg <= addr_fix[ADDR_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
            vd_reg <= 1'b0;
        end else begin
            va_reg <= ctrl.gather_run;
            vb_reg <= va_reg;
            vc_reg <= vb_reg;
            vd_reg <= vc_reg;
        end
    end

    rmwf_line_store #(.DEPTH(DEPTH)) u_store (
        .aclk    (aclk),
        .wr_en   (pix_take),
        .wr_addr (in_addr_reg),
        .wr_data (s_tdata),
        .rd_addr (rd_addr_reg),
        .rd_data (rd_data)
    );

    assign bus = vd_reg ? rd_data : '1;

    rmwf_sort_chain #(.NCELL(NCELL)) u_chain (
        .aclk       (aclk),
        .clear      (ctrl.chain_clear),
        .start_idx  (start_reg),
        .bus_in     (bus),
        .median_out (median)
    );

    // output register
    logic        m_valid_reg;
    logic [31:0] m_data_reg;
    logic        m_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) m_valid_reg <= 1'b0;
        else if (ctrl.load_result) m_valid_reg <= 1'b1;
        else if (m_tready) m_valid_reg <= 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load_result) begin
            m_data_reg <= median;
            m_last_reg <= out_col_last && out_row_last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

    `RMWF_ASSERT_ALWAYS(a_addr_range, aclk, aresetn, in_addr_reg < ADDR_W'(DEPTH))
    `RMWF_ASSERT_ALWAYS(a_complete_col, aclk, aresetn, !complete_reg || in_col_reg == '0)
    `RMWF_ASSERT_ALWAYS(a_out_behind, aclk, aresetn, complete_reg || out_row_reg <= in_row_reg)
    `RMWF_ASSERT_IMPL(a_result_after_flush, aclk, aresetn, state_reg == ST_RESULT,
        $past(state_reg) == ST_FLUSH || $past(state_reg) == ST_RESULT)
endmodule
`default_nettype wire
